### rtl/lcdns_pkg.sv
// Package with the shared types, codes and timing constants of the LCD nibble sequencer.
`timescale 1ns / 1ps

package lcdns_pkg;

  localparam int unsigned JOB_DEPTH_DEFAULT = 2;

  localparam logic [2:0] REQ_INIT  = 3'd0;
  localparam logic [2:0] REQ_CMD   = 3'd1;
  localparam logic [2:0] REQ_CHAR  = 3'd2;
  localparam logic [2:0] REQ_CLEAR = 3'd3;
  localparam logic [2:0] REQ_GOTO  = 3'd4;

  localparam logic [2:0] CFG_ENABLE_PULSE  = 3'd0;
  localparam logic [2:0] CFG_NIBBLE_SETTLE = 3'd1;
  localparam logic [2:0] CFG_FUNCTION_SET  = 3'd2;
  localparam logic [2:0] CFG_DISPLAY_CTRL  = 3'd3;
  localparam logic [2:0] CFG_ENTRY_MODE    = 3'd4;

  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] ADDR_LINE0 = 8'h80;
  localparam logic [7:0] ADDR_LINE1 = 8'hC0;
  localparam logic [5:0] COLUMN_MAX = 6'd39;
  localparam logic [3:0] NIB_WAKE   = 4'h3;
  localparam logic [3:0] NIB_4BIT   = 4'h2;

  localparam logic [14:0] INIT_WAIT_US         = 15'd20000;
  localparam logic [13:0] INIT_NIBBLE_EXTRA_US = 14'd10000;
  localparam logic [13:0] CLEAR_EXTRA_US       = 14'd5000;
  localparam logic [13:0] GOTO_EXTRA_US        = 14'd50;

  localparam logic [3:0] INIT_LAST_STEP = 4'd11;

  typedef enum logic [1:0] {
    EXTRA_NONE,
    EXTRA_CLEAR,
    EXTRA_GOTO
  } extra_t;

  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
    extra_t     extra;
  } job_t;

  typedef struct packed {
    logic [7:0] enable_pulse_us;
    logic [7:0] nibble_settle_us;
    logic [7:0] function_set_byte;
    logic [7:0] display_control_byte;
    logic [7:0] entry_mode_byte;
  } cfg_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [14:0] wait_before_us;
    logic [7:0]  enable_high_us;
    logic [13:0] wait_after_us;
    logic        last;
  } wr_t;

endpackage

### rtl/lcdns_front.sv
// Front end that accepts requests and turns each valid one into a job descriptor.
`timescale 1ns / 1ps

module lcdns_front
  import lcdns_pkg::*;
(
  input  logic       in_push,
  input  logic       job_full,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_byte_value,
  input  logic       in_row,
  input  logic [5:0] in_column,
  output logic       in_full,
  output logic       job_push,
  output job_t       job
);

  logic       valid_type;
  logic [5:0] col_sat;

  assign col_sat = (in_column > COLUMN_MAX) ? COLUMN_MAX : in_column;

  always_comb begin
    valid_type = 1'b1;
    job = '{is_init: 1'b0, rs: 1'b0, data: in_byte_value, extra: EXTRA_NONE};
    unique case (in_req_type)
      REQ_INIT: begin
        job.is_init = 1'b1;
      end
      REQ_CMD: begin
      end
      REQ_CHAR: begin
        job.rs = 1'b1;
      end
      REQ_CLEAR: begin
        job.data  = CMD_CLEAR;
        job.extra = EXTRA_CLEAR;
      end
      REQ_GOTO: begin
        job.data  = (in_row ? ADDR_LINE1 : ADDR_LINE0) + {2'b00, col_sat};
        job.extra = EXTRA_GOTO;
      end
      default: begin
        valid_type = 1'b0;
      end
    endcase
  end

  assign in_full  = job_full;
  assign job_push = in_push && !job_full && valid_type;

endmodule

### rtl/lcdns_job_fifo.sv
// Short job queue between the front end and the write sequencer.
`timescale 1ns / 1ps

module lcdns_job_fifo
  import lcdns_pkg::*;
#(
  parameter int unsigned DEPTH = JOB_DEPTH_DEFAULT
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/lcdns_back.sv
// Back end that steps through a job and issues one timed nibble write per cycle unless a held result stalls it.
`timescale 1ns / 1ps

module lcdns_back
  import lcdns_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic job_empty,
  input  job_t job_head,
  output logic job_pop,
  input  logic out_pop,
  output logic out_empty,
  output wr_t  out_wr
);

  job_t       cur_r;
  logic       busy_r;
  logic [3:0] step_r;
  logic       out_valid_r;
  wr_t        out_r;
  wr_t        wr_nxt;
  logic       advance;
  logic       load;
  logic [7:0] init_byte;
  logic [7:0] run_byte;
  logic       low_half;

  assign advance   = busy_r && (!out_valid_r || out_pop);
  assign load      = !job_empty && (!busy_r || (advance && wr_nxt.last));
  assign job_pop   = load;
  assign out_empty = !out_valid_r;
  assign out_wr    = out_r;

  always_comb begin
    unique case (step_r[3:1])
      3'd2:    init_byte = cfg.function_set_byte;
      3'd3:    init_byte = cfg.display_control_byte;
      3'd4:    init_byte = cfg.entry_mode_byte;
      default: init_byte = CMD_CLEAR;
    endcase
  end

  always_comb begin
    run_byte = cur_r.is_init ? init_byte : cur_r.data;
    low_half = step_r[0];
    wr_nxt.reg_select     = cur_r.rs;
    wr_nxt.enable_high_us = cfg.enable_pulse_us;
    wr_nxt.wait_before_us = '0;
    wr_nxt.nibble         = low_half ? run_byte[3:0] : run_byte[7:4];
    wr_nxt.wait_after_us  = {6'd0, cfg.nibble_settle_us};
    if (cur_r.is_init) begin
      wr_nxt.last = (step_r == INIT_LAST_STEP);
      if (step_r < 4'd4) begin
        wr_nxt.nibble        = (step_r == 4'd3) ? NIB_4BIT : NIB_WAKE;
        wr_nxt.wait_after_us = {6'd0, cfg.nibble_settle_us} + INIT_NIBBLE_EXTRA_US;
        if (step_r == 4'd0) begin
          wr_nxt.wait_before_us = INIT_WAIT_US;
        end
      end
    end else begin
      wr_nxt.last = low_half;
      if (low_half) begin
        case (cur_r.extra)
          EXTRA_CLEAR: wr_nxt.wait_after_us = {6'd0, cfg.nibble_settle_us} + CLEAR_EXTRA_US;
          EXTRA_GOTO:  wr_nxt.wait_after_us = {6'd0, cfg.nibble_settle_us} + GOTO_EXTRA_US;
          default:     wr_nxt.wait_after_us = {6'd0, cfg.nibble_settle_us};
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= job_head;
    end
    if (advance) begin
      out_r <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (advance) begin
        if (wr_nxt.last) begin
          busy_r <= 1'b0;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

endmodule

### rtl/char_lcd_nibble_sequencer_unit.sv
// Top level of the character LCD nibble sequencer with its configuration registers.
//
//   channel  ports                                   transfer when
//   input    in_push / in_full, request fields       in_push && !in_full
//   result   out_pop / out_empty, write fields       out_pop && !out_empty
//   config   cfg_valid / cfg_ready, index and data   cfg_valid && cfg_ready
//
// A request enters the job queue in the cycle it is taken, so a new request may be taken
// every cycle until the queue fills. The sequencer issues one write per cycle unless a held
// result stalls it: two for a command, character, clear or goto, and twelve for init.
// Reset returns the registers to their defaults and empties the queue and the output
// register. A held result stalls the sequencer, and a full queue raises in_full.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_unit
  import lcdns_pkg::*;
#(
  parameter int unsigned JOB_DEPTH = JOB_DEPTH_DEFAULT
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_byte_value,
  input  logic        in_row,
  input  logic [5:0]  in_column,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_reg_select,
  output logic [3:0]  out_nibble,
  output logic [14:0] out_wait_before_us,
  output logic [7:0]  out_enable_high_us,
  output logic [13:0] out_wait_after_us,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t cfg_r;
  job_t front_job;
  job_t head_job;
  logic job_push;
  logic job_pop;
  logic job_full;
  logic job_empty;
  wr_t  wr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_pulse_us      <= 8'd5;
      cfg_r.nibble_settle_us     <= 8'd40;
      cfg_r.function_set_byte    <= 8'h28;
      cfg_r.display_control_byte <= 8'h0C;
      cfg_r.entry_mode_byte      <= 8'h06;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENABLE_PULSE:  cfg_r.enable_pulse_us      <= cfg_data;
        CFG_NIBBLE_SETTLE: cfg_r.nibble_settle_us     <= cfg_data;
        CFG_FUNCTION_SET:  cfg_r.function_set_byte    <= cfg_data;
        CFG_DISPLAY_CTRL:  cfg_r.display_control_byte <= cfg_data;
        CFG_ENTRY_MODE:    cfg_r.entry_mode_byte      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lcdns_front u_front (
    .in_push       (in_push),
    .job_full      (job_full),
    .in_req_type   (in_req_type),
    .in_byte_value (in_byte_value),
    .in_row        (in_row),
    .in_column     (in_column),
    .in_full       (in_full),
    .job_push      (job_push),
    .job           (front_job)
  );

  lcdns_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (front_job),
    .pop      (job_pop),
    .full     (job_full),
    .empty    (job_empty),
    .head     (head_job)
  );

  lcdns_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_empty (job_empty),
    .job_head  (head_job),
    .job_pop   (job_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_wr    (wr)
  );

  assign out_reg_select     = wr.reg_select;
  assign out_nibble         = wr.nibble;
  assign out_wait_before_us = wr.wait_before_us;
  assign out_enable_high_us = wr.enable_high_us;
  assign out_wait_after_us  = wr.wait_after_us;
  assign out_last           = wr.last;

endmodule
